// ===== rtl/blm_pkg.sv =====
// Shared types and constants for the battery level monitor.
// Holds field widths, register reset values, divider constants and config codes.
// No dependencies.
package blm_pkg;

  localparam int unsigned AVG_COUNT_DEF = 40;

  localparam int unsigned SAMPLE_W = 14;
  localparam int unsigned CUR_W    = 16;
  localparam int unsigned REG_W    = 13;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [REG_W-1:0] BASE_THR_RST    = 13'd3700;
  localparam logic [REG_W-1:0] THR_FLOOR_RST   = 13'd3300;
  localparam logic [REG_W-1:0] VLOW_ENTER_RST  = 13'd2950;
  localparam logic [REG_W-1:0] VLOW_EXIT_RST   = 13'd3200;
  localparam logic [REG_W-1:0] FAULT_LIMIT_RST = 13'd2750;

  localparam logic [LEVEL_W-1:0] LEVEL_PLENTY   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MID      = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW      = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_VERY_LOW = 2'd3;

  localparam int unsigned CMP_W = 15;
  localparam logic [CMP_W-1:0] PLENTY_EXIT_MARGIN = 15'd250;
  localparam logic [CMP_W-1:0] LOW_ENTER_MARGIN   = 15'd200;
  localparam logic [CMP_W-1:0] MID_EXIT_MARGIN    = 15'd50;

  // Exact reciprocals for 16-bit current divided by 10 and 15.
  localparam logic [CUR_W-1:0] DIV10_RECIP = 16'd52429;
  localparam logic [CUR_W-1:0] DIV15_RECIP = 16'd34953;
  localparam int unsigned CUR_RECIP_SHIFT = 19;

  // Reciprocal for the trimmed sum divided by AVG_COUNT-2.
  localparam int unsigned AVG_RECIP_SHIFT = 26;
  localparam int unsigned AVG_RECIP_W     = AVG_RECIP_SHIFT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_THR    = 3'd0,
    CFG_THR_FLOOR   = 3'd1,
    CFG_VLOW_ENTER  = 3'd2,
    CFG_VLOW_EXIT   = 3'd3,
    CFG_FAULT_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] base_threshold_mv;
    logic [REG_W-1:0] threshold_floor_mv;
    logic [REG_W-1:0] very_low_enter_mv;
    logic [REG_W-1:0] very_low_exit_mv;
    logic [REG_W-1:0] fault_limit_mv;
  } cfg_regs_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_mv;
    logic [SAMPLE_W-1:0] alert_threshold_mv;
    logic                light_off;
    logic [REG_W-1:0]    threshold_mv;
  } stage_item_t;

endpackage

// ===== rtl/blm_in_if.sv =====
// Input channel of the battery level monitor: valid/ready plus one sample item.
// Depends on blm_pkg.
interface blm_in_if;
  logic                          valid;
  logic                          ready;
  logic [blm_pkg::SAMPLE_W-1:0]  sample_mv;
  logic [blm_pkg::CUR_W-1:0]     load_current_ma;
  logic                          high_power_mode;
  logic                          light_off;
  logic [blm_pkg::SAMPLE_W-1:0]  alert_threshold_mv;

  modport source (output valid, sample_mv, load_current_ma, high_power_mode, light_off,
                  alert_threshold_mv, input ready);
  modport sink (input valid, sample_mv, load_current_ma, high_power_mode, light_off,
                alert_threshold_mv, output ready);
endinterface

// ===== rtl/blm_out_if.sv =====
// Result channel of the battery level monitor: valid/ready plus one result item.
// Depends on blm_pkg.
interface blm_out_if;
  logic                          valid;
  logic                          ready;
  logic [blm_pkg::LEVEL_W-1:0]   charge_level;
  logic                          alert_flag;
  logic                          fault_flag;
  logic [blm_pkg::SAMPLE_W-1:0]  cell_voltage_mv;
  logic                          average_updated;

  modport source (output valid, charge_level, alert_flag, fault_flag, cell_voltage_mv,
                  average_updated, input ready);
  modport sink (input valid, charge_level, alert_flag, fault_flag, cell_voltage_mv,
                average_updated, output ready);
endinterface

// ===== rtl/blm_cfg.sv =====
// Configuration register file for the battery level monitor.
// Depends on blm_pkg.
module blm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [blm_pkg::REG_W-1:0]       cfg_wdata,
  output blm_pkg::cfg_regs_t              cfg_regs
);

  blm_pkg::cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_threshold_mv  <= blm_pkg::BASE_THR_RST;
      cfg_r.threshold_floor_mv <= blm_pkg::THR_FLOOR_RST;
      cfg_r.very_low_enter_mv  <= blm_pkg::VLOW_ENTER_RST;
      cfg_r.very_low_exit_mv   <= blm_pkg::VLOW_EXIT_RST;
      cfg_r.fault_limit_mv     <= blm_pkg::FAULT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (blm_pkg::cfg_idx_t'(cfg_idx))
        blm_pkg::CFG_BASE_THR:    cfg_r.base_threshold_mv  <= cfg_wdata;
        blm_pkg::CFG_THR_FLOOR:   cfg_r.threshold_floor_mv <= cfg_wdata;
        blm_pkg::CFG_VLOW_ENTER:  cfg_r.very_low_enter_mv  <= cfg_wdata;
        blm_pkg::CFG_VLOW_EXIT:   cfg_r.very_low_exit_mv   <= cfg_wdata;
        blm_pkg::CFG_FAULT_LIMIT: cfg_r.fault_limit_mv     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_regs = cfg_r;

endmodule

// ===== rtl/blm_thresh.sv =====
// Input stage: takes an item and registers it with its current-compensated threshold.
// Depends on blm_pkg and blm_in_if.
module blm_thresh (
  input  logic                  clk,
  input  logic                  rst_n,
  input  blm_pkg::cfg_regs_t    cfg_regs,
  blm_in_if.sink                in_ch,
  input  logic                  stage_take,
  output logic                  stage_valid,
  output blm_pkg::stage_item_t  stage_item
);

  localparam int unsigned ProdW = 2 * blm_pkg::CUR_W;
  localparam int unsigned RegW  = blm_pkg::REG_W;
  localparam int unsigned CmpW  = blm_pkg::CMP_W;

  logic                  valid_r;
  blm_pkg::stage_item_t  item_r;
  blm_pkg::stage_item_t  item_nxt;
  logic                  accept;
  logic [ProdW-1:0]      prod;
  logic [RegW-1:0]       quot;
  logic [CmpW-1:0]       diff;
  logic [CmpW-1:0]       floor_w;

  assign in_ch.ready = !valid_r || stage_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    prod = ProdW'(in_ch.load_current_ma) *
           ProdW'(in_ch.high_power_mode ? blm_pkg::DIV10_RECIP : blm_pkg::DIV15_RECIP);
    quot    = prod[blm_pkg::CUR_RECIP_SHIFT +: RegW];
    diff    = CmpW'(cfg_regs.base_threshold_mv) - CmpW'(quot);
    floor_w = CmpW'(cfg_regs.threshold_floor_mv);
    item_nxt.sample_mv          = in_ch.sample_mv;
    item_nxt.alert_threshold_mv = in_ch.alert_threshold_mv;
    item_nxt.light_off          = in_ch.light_off;
    item_nxt.threshold_mv       = ($signed(diff) < $signed(floor_w)) ?
                                  cfg_regs.threshold_floor_mv : diff[RegW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (stage_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

// ===== rtl/blm_core.sv =====
// Averaging and charge level stage: trimmed mean, flags and hysteresis state.
// Depends on blm_pkg and blm_out_if.
module blm_core #(
  parameter int unsigned AVG_COUNT = blm_pkg::AVG_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  blm_pkg::cfg_regs_t    cfg_regs,
  input  logic                  stage_valid,
  input  blm_pkg::stage_item_t  stage_item,
  output logic                  stage_take,
  blm_out_if.source             out_ch
);

  localparam int unsigned SampleW = blm_pkg::SAMPLE_W;
  localparam int unsigned SumW    = blm_pkg::SUM_W;
  localparam int unsigned CntW    = blm_pkg::CNT_W;
  localparam int unsigned CmpW    = blm_pkg::CMP_W;
  localparam int unsigned RecipW  = blm_pkg::AVG_RECIP_W;
  localparam int unsigned ProdW   = SumW + RecipW;
  localparam int unsigned Divisor = AVG_COUNT - 2;
  localparam logic [RecipW-1:0] AvgRecip =
    RecipW'(((64'd1 << blm_pkg::AVG_RECIP_SHIFT) + 64'(Divisor) - 64'd1) / 64'(Divisor));

  typedef enum logic [blm_pkg::LEVEL_W-1:0] {
    LVL_PLENTY   = blm_pkg::LEVEL_PLENTY,
    LVL_MID      = blm_pkg::LEVEL_MID,
    LVL_LOW      = blm_pkg::LEVEL_LOW,
    LVL_VERY_LOW = blm_pkg::LEVEL_VERY_LOW
  } level_t;

  level_t               level_r, level_nxt;
  logic [SumW-1:0]      sum_r, sum_nxt;
  logic [SampleW-1:0]   min_r, min_nxt;
  logic [SampleW-1:0]   max_r, max_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [SampleW-1:0]   avg_r, avg_nxt;
  logic                 out_valid_r;
  logic                 alert_r, alert_nxt;
  logic                 fault_r, fault_nxt;
  logic                 updated_r, update;

  logic [SampleW:0]     drop;
  logic [SumW-1:0]      rest;
  logic [ProdW-1:0]     prod;
  logic [CmpW-1:0]      cell_w, thr_w;
  logic                 go_mid, go_plenty, go_low, up_mid, go_vlow, up_low;

  assign stage_take = stage_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    update  = cnt_r >= CntW'(AVG_COUNT);
    drop    = {1'b0, min_r} + {1'b0, max_r};
    rest    = (sum_r >= SumW'(drop)) ? sum_r - SumW'(drop) : '0;
    prod    = ProdW'(rest) * ProdW'(AvgRecip);
    sum_nxt = sum_r + SumW'(stage_item.sample_mv);
    cnt_nxt = cnt_r + CntW'(1);
    min_nxt = (stage_item.sample_mv < min_r) ? stage_item.sample_mv : min_r;
    max_nxt = (stage_item.sample_mv > max_r) ? stage_item.sample_mv : max_r;
    avg_nxt = update ? prod[blm_pkg::AVG_RECIP_SHIFT +: SampleW] : avg_r;

    fault_nxt = avg_nxt <= SampleW'(cfg_regs.fault_limit_mv);
    alert_nxt = !fault_nxt && (avg_nxt <= stage_item.alert_threshold_mv);

    cell_w    = CmpW'(avg_nxt);
    thr_w     = CmpW'(stage_item.threshold_mv);
    go_mid    = cell_w < thr_w;
    go_plenty = stage_item.light_off && (cell_w > thr_w + blm_pkg::PLENTY_EXIT_MARGIN);
    go_low    = (cell_w + blm_pkg::LOW_ENTER_MARGIN) < thr_w;
    up_mid    = stage_item.light_off && (cell_w > thr_w + blm_pkg::MID_EXIT_MARGIN);
    go_vlow   = cell_w < CmpW'(cfg_regs.very_low_enter_mv);
    up_low    = stage_item.light_off && (cell_w > CmpW'(cfg_regs.very_low_exit_mv));

    level_nxt = level_r;
    unique case (level_r)
      LVL_PLENTY: begin
        if (go_mid) level_nxt = LVL_MID;
      end
      LVL_MID: begin
        if (go_low) level_nxt = LVL_LOW;
        else if (go_plenty) level_nxt = LVL_PLENTY;
      end
      LVL_LOW: begin
        if (go_vlow) level_nxt = LVL_VERY_LOW;
        else if (up_mid) level_nxt = LVL_MID;
      end
      LVL_VERY_LOW: begin
        if (up_low) level_nxt = LVL_LOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LVL_PLENTY;
      sum_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
      cnt_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_take) begin
        level_r     <= level_nxt;
        avg_r       <= avg_nxt;
        out_valid_r <= 1'b1;
        if (update) begin
          sum_r <= '0;
          min_r <= '1;
          max_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          min_r <= min_nxt;
          max_r <= max_nxt;
          cnt_r <= cnt_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take) begin
      alert_r   <= alert_nxt;
      fault_r   <= fault_nxt;
      updated_r <= update;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.charge_level    = level_r;
  assign out_ch.alert_flag      = alert_r;
  assign out_ch.fault_flag      = fault_r;
  assign out_ch.cell_voltage_mv = avg_r;
  assign out_ch.average_updated = updated_r;

endmodule

// ===== rtl/battery_level_monitor.sv =====
// Top level of the battery level monitor: config registers, input stage, core stage.
// Depends on blm_pkg, blm_in_if, blm_out_if, blm_cfg, blm_thresh and blm_core.
//
//   Channel  Direction  Handshake             Payload
//   in_ch    sink       valid/ready           sample, current, mode flags, alert limit
//   out_ch   source     valid/ready           level, alert, fault, cell voltage, updated
//   cfg_*    sink       cfg_we (no back-pressure)  cfg_idx, cfg_wdata
//
// One item is taken per clock unless the output stalls; it passes the input-stage
// register and then the core-stage output registers. The current divider sits in the
// input stage, the trimmed-mean divider and the level logic in the core stage. Reset
// is synchronous; the item register and alert, fault and updated flags are not reset.
// When the output stalls, the input stage holds one item and then deasserts ready.
module battery_level_monitor #(
  parameter int unsigned AVG_COUNT = blm_pkg::AVG_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  blm_in_if.sink                          in_ch,
  blm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [blm_pkg::REG_W-1:0]       cfg_wdata
);

  blm_pkg::cfg_regs_t    cfg_regs;
  blm_pkg::stage_item_t  stage_item;
  logic                  stage_valid;
  logic                  stage_take;

  blm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_regs  (cfg_regs)
  );

  blm_thresh u_thresh (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_regs    (cfg_regs),
    .in_ch       (in_ch),
    .stage_take  (stage_take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  blm_core #(
    .AVG_COUNT (AVG_COUNT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_regs    (cfg_regs),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_take  (stage_take),
    .out_ch      (out_ch)
  );

endmodule

// ===== rtl/blm_checker.sv =====
// Port-level checks for the battery level monitor, attached by bind.
// Depends on blm_pkg.
module blm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [blm_pkg::LEVEL_W-1:0]    charge_level,
  input logic                           alert_flag,
  input logic                           fault_flag,
  input logic [blm_pkg::SAMPLE_W-1:0]   cell_voltage_mv,
  input logic                           average_updated
);

  logic                          have_prev_r;
  logic [blm_pkg::LEVEL_W-1:0]   prev_level_r;
  logic [blm_pkg::SAMPLE_W-1:0]  prev_cell_r;
  logic                          xfer;
  logic                          level_step_ok;

  assign xfer = out_valid && out_ready;
  assign level_step_ok = (charge_level == prev_level_r) ||
                         (charge_level == prev_level_r + 2'd1) ||
                         (charge_level == prev_level_r - 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (xfer) begin
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      prev_level_r <= charge_level;
      prev_cell_r  <= cell_voltage_mv;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(alert_flag && fault_flag))
    else $error("alert and fault flags both set");

  a_level_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && have_prev_r &&
    !(prev_level_r == blm_pkg::LEVEL_VERY_LOW && charge_level == blm_pkg::LEVEL_PLENTY) &&
    !(prev_level_r == blm_pkg::LEVEL_PLENTY && charge_level == blm_pkg::LEVEL_VERY_LOW)
    |-> level_step_ok)
    else $error("charge level moved by more than one step");

  a_level_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && have_prev_r |->
    !(prev_level_r == blm_pkg::LEVEL_VERY_LOW && charge_level == blm_pkg::LEVEL_PLENTY) &&
    !(prev_level_r == blm_pkg::LEVEL_PLENTY && charge_level == blm_pkg::LEVEL_VERY_LOW))
    else $error("charge level jumped between plenty and very low");

  a_cell_held: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && have_prev_r && !average_updated |-> cell_voltage_mv == prev_cell_r)
    else $error("cell voltage changed without a new average");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(charge_level) &&
                                $stable(cell_voltage_mv) && $stable(average_updated))
    else $error("result changed while stalled");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .charge_level    (out_ch.charge_level),
  .alert_flag      (out_ch.alert_flag),
  .fault_flag      (out_ch.fault_flag),
  .cell_voltage_mv (out_ch.cell_voltage_mv),
  .average_updated (out_ch.average_updated)
);
